FILE: design/barcode_check_digit_encoder_defines.svh
// Assertion macros for the barcode check digit encoder; the back end includes them.
`ifndef BARCODE_CHECK_DIGIT_ENCODER_DEFINES_SVH
`define BARCODE_CHECK_DIGIT_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BCDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bcde_pkg.sv
// Package with types, constants and pattern lookup for the barcode check digit encoder.
package bcde_pkg;

  localparam int CODE_W      = 20;
  localparam int DIGIT_W     = 4;
  localparam int PAT_W       = 14;
  localparam int LEN_W       = 4;
  localparam int NUM_DIGITS  = 6;
  localparam int CNT_W       = 3;
  localparam int SUM_W       = 6;
  localparam int PROD_W      = 40;
  localparam int QUO_W       = 17;
  localparam int RECIP_SHIFT = 23;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CODE_W-1:0]  MAX_CODE  = 20'd999999;
  localparam logic [CODE_W-1:0]  RECIP_10  = 20'd838861;
  localparam logic [7:0]         START_PAT = 8'hDA;
  localparam logic [7:0]         STOP_PAT  = 8'hD6;
  localparam logic [LEN_W-1:0]   EDGE_LEN  = 4'd8;
  localparam logic [LEN_W-1:0]   DIGIT_LEN = 4'd14;
  localparam logic [DIGIT_W-1:0] MAX_DIGIT = 4'd9;

  localparam logic [CNT_W-1:0] SYM_START = 3'd0;
  localparam logic [CNT_W-1:0] LAST_DIGIT_STEP = 3'd5;
  localparam logic [CNT_W-1:0] DIGITS_DONE = 3'd6;

  localparam logic [3:0] SYM_IDX_START = 4'd0;
  localparam logic [3:0] SYM_IDX_CHECK = 4'd7;
  localparam logic [3:0] SYM_IDX_STOP  = 4'd8;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    digits_t              digits;
    logic [DIGIT_W-1:0]   check;
  } rec_t;

  function automatic logic [PAT_W-1:0] digit_pattern(input logic [DIGIT_W-1:0] d);
    logic [PAT_W-1:0] p;
    unique case (d)
      4'd0:    p = 14'h2BBA;
      4'd1:    p = 14'h3AAE;
      4'd2:    p = 14'h2EAE;
      4'd3:    p = 14'h3BAA;
      4'd4:    p = 14'h2BAE;
      4'd5:    p = 14'h3AEA;
      4'd6:    p = 14'h2EEA;
      4'd7:    p = 14'h2AEE;
      4'd8:    p = 14'h3ABA;
      4'd9:    p = 14'h2EBA;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: design/bcde_front.sv
// Front end: accepts codes, saturates them, splits digits and computes the check digit.
module bcde_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [19:0]              in_code_value,
  output logic                     push,
  output bcde_pkg::rec_t           push_rec,
  input  logic                     q_full
);
  import bcde_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CODE_W-1:0]     val_r, val_nxt;
  logic [DIGIT_W-1:0]    acc_r, acc_nxt;
  digits_t               digits_r, digits_nxt;

  logic                  accept;
  logic                  stepping;
  logic [PROD_W-1:0]     prod;
  logic [QUO_W-1:0]      quo;
  logic [CODE_W-1:0]     quo_x10;
  logic [CODE_W-1:0]     rem;
  logic [DIGIT_W-1:0]    digit;
  logic [SUM_W-1:0]      weighted;
  logic [SUM_W-1:0]      sum;
  logic [DIGIT_W-1:0]    sum_mod;
  logic [DIGIT_W-1:0]    check;

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign stepping = busy_r && (cnt_r != DIGITS_DONE);
  assign push     = busy_r && (cnt_r == DIGITS_DONE) && !q_full;

  // Division by ten through a reciprocal multiply; exact for all 20-bit values.
  assign prod    = PROD_W'(val_r) * PROD_W'(RECIP_10);
  assign quo     = prod[RECIP_SHIFT +: QUO_W];
  assign quo_x10 = CODE_W'({quo, 3'b000}) + CODE_W'({quo, 1'b0});
  assign rem     = val_r - quo_x10;
  assign digit   = rem[DIGIT_W-1:0];

  // Units, hundreds and ten-thousands carry weight three.
  assign weighted = cnt_r[0] ? SUM_W'(digit)
                             : SUM_W'({digit, 1'b0}) + SUM_W'(digit);
  assign sum      = SUM_W'(acc_r) + weighted;

  always_comb begin
    priority if (sum >= SUM_W'(30)) begin
      sum_mod = DIGIT_W'(sum - SUM_W'(30));
    end else if (sum >= SUM_W'(20)) begin
      sum_mod = DIGIT_W'(sum - SUM_W'(20));
    end else if (sum >= SUM_W'(10)) begin
      sum_mod = DIGIT_W'(sum - SUM_W'(10));
    end else begin
      sum_mod = DIGIT_W'(sum);
    end
  end

  assign check           = (acc_r == '0) ? '0 : DIGIT_W'(4'd10 - acc_r);
  assign push_rec.digits = digits_r;
  assign push_rec.check  = check;

  always_comb begin
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    val_nxt    = val_r;
    acc_nxt    = acc_r;
    digits_nxt = digits_r;
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      val_nxt  = (in_code_value > MAX_CODE) ? MAX_CODE : in_code_value;
      acc_nxt  = '0;
    end else if (stepping) begin
      val_nxt         = CODE_W'(quo);
      acc_nxt         = sum_mod;
      digits_nxt[cnt_r] = digit;
      cnt_nxt         = cnt_r + CNT_W'(1);
    end else if (push) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    acc_r    <= acc_nxt;
    digits_r <= digits_nxt;
  end

endmodule

FILE: design/bcde_queue.sv
// Small queue of digit records between the front end and the symbol sequencer.
module bcde_queue #(
  parameter int DEPTH = bcde_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bcde_pkg::rec_t  push_rec,
  input  logic            pop,
  output bcde_pkg::rec_t  head_rec,
  output logic            full,
  output logic            empty
);
  import bcde_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  rec_t               mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == COUNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

FILE: design/bcde_back.sv
// Back end: steps through the nine symbols of each record into the output register.
module bcde_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bcde_pkg::rec_t  head_rec,
  input  logic            q_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [13:0]     out_pattern,
  output logic [3:0]      out_pattern_length,
  output logic [3:0]      out_check_digit,
  output logic            out_last
);
  import bcde_pkg::*;

  `include "barcode_check_digit_encoder_defines.svh"

  rec_t               rec_r, rec_nxt;
  logic               rec_valid_r, rec_valid_nxt;
  logic [3:0]         sym_r, sym_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PAT_W-1:0]   out_pattern_r, out_pattern_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic [DIGIT_W-1:0] out_chk_r, out_chk_nxt;
  logic               out_last_r, out_last_nxt;

  logic               adv;
  logic               finish;
  logic [CNT_W-1:0]   digit_idx;
  logic [DIGIT_W-1:0] sym_digit;

  assign adv    = rec_valid_r && (!out_valid_r || !out_stall);
  assign finish = adv && (sym_r == SYM_IDX_STOP);
  assign pop    = !q_empty && (!rec_valid_r || finish);

  // Symbols one to six carry the digits, most significant first.
  assign digit_idx = CNT_W'(4'd6 - sym_r);

  always_comb begin
    unique case (sym_r)
      SYM_IDX_CHECK: sym_digit = rec_r.check;
      default:       sym_digit = rec_r.digits[digit_idx];
    endcase
  end

  always_comb begin
    rec_nxt         = rec_r;
    rec_valid_nxt   = rec_valid_r;
    sym_nxt         = sym_r;
    out_valid_nxt   = out_valid_r;
    out_pattern_nxt = out_pattern_r;
    out_len_nxt     = out_len_r;
    out_chk_nxt     = out_chk_r;
    out_last_nxt    = out_last_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_chk_nxt   = rec_r.check;
      out_last_nxt  = (sym_r == SYM_IDX_STOP);
      unique case (sym_r)
        SYM_IDX_START: begin
          out_pattern_nxt = PAT_W'(START_PAT);
          out_len_nxt     = EDGE_LEN;
        end
        SYM_IDX_STOP: begin
          out_pattern_nxt = PAT_W'(STOP_PAT);
          out_len_nxt     = EDGE_LEN;
        end
        default: begin
          out_pattern_nxt = digit_pattern(sym_digit);
          out_len_nxt     = DIGIT_LEN;
        end
      endcase
      sym_nxt = sym_r + 4'd1;
    end
    if (finish) begin
      rec_valid_nxt = 1'b0;
    end
    if (pop) begin
      rec_nxt       = head_rec;
      rec_valid_nxt = 1'b1;
      sym_nxt       = SYM_IDX_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      sym_r       <= SYM_IDX_START;
      out_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
      sym_r       <= sym_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r         <= rec_nxt;
    out_pattern_r <= out_pattern_nxt;
    out_len_r     <= out_len_nxt;
    out_chk_r     <= out_chk_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_pattern        = out_pattern_r;
  assign out_pattern_length = out_len_r;
  assign out_check_digit    = out_chk_r;
  assign out_last           = out_last_r;

  `BCDE_ASSERT_NOW(a_sym_range, rec_valid_r, sym_r <= SYM_IDX_STOP, "Symbol index out of range.")
  `BCDE_ASSERT_NOW(a_last_len, out_valid_r && out_last_r, out_len_r == EDGE_LEN, "Stop symbol has wrong length.")
  `BCDE_ASSERT_NOW(a_chk_range, out_valid_r, out_chk_r <= MAX_DIGIT, "Check digit out of range.")
  `BCDE_ASSERT_NEXT(a_finish_pop, finish && q_empty, !rec_valid_r, "Record kept after its stop symbol.")

endmodule

FILE: design/barcode_check_digit_encoder.sv
// Top level of the barcode check digit encoder.
// Each accepted code yields nine symbols (start, six digits, check digit, stop), one per
// cycle from the output register while out_stall does not hold them; the symbol sequencer,
// which moves one symbol per transfer, limits how often a new code is taken. The front end
// splits the digits with one divide-by-ten multiply per cycle, and a small record queue lets
// it run ahead of the sequencer.
module barcode_check_digit_encoder #(
  parameter int QUEUE_DEPTH = bcde_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_code_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_pattern,
  output logic [3:0]  out_pattern_length,
  output logic [3:0]  out_check_digit,
  output logic        out_last
);
  import bcde_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  rec_t push_rec;
  rec_t head_rec;

  bcde_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_value (in_code_value),
    .push          (push),
    .push_rec      (push_rec),
    .q_full        (q_full)
  );

  bcde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  bcde_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_rec           (head_rec),
    .q_empty            (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pattern        (out_pattern),
    .out_pattern_length (out_pattern_length),
    .out_check_digit    (out_check_digit),
    .out_last           (out_last)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the check-digit barcode encoder, with a built-in symbol predictor.
module testbench;

  typedef struct {
    logic [13:0] pattern;
    logic [3:0]  length;
    logic [3:0]  check;
    logic        last;
  } symbol_t;

  localparam int          HALF_PERIOD = 6;
  localparam int          RESET_CYCLES = 12;
  localparam int          MAX_IDLE = 13;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          TIMEOUT_CYCLES = 1_000_000;
  localparam int          LARGEST_CODE = 999999;
  localparam logic [13:0] FRAME_START = 14'h00DA;
  localparam logic [13:0] FRAME_STOP = 14'h00D6;
  localparam logic [3:0]  EDGE_BITS = 4'd8;
  localparam logic [3:0]  DIGIT_BITS = 4'd14;
  localparam logic [9:0][13:0] BAR_TABLE = {
    14'h2EBA, 14'h3ABA, 14'h2AEE, 14'h2EEA, 14'h3AEA,
    14'h2BAE, 14'h3BAA, 14'h2EAE, 14'h3AAE, 14'h2BBA
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [19:0] in_code_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] out_pattern;
  logic [3:0]  out_pattern_length;
  logic [3:0]  out_check_digit;
  logic        out_last;

  symbol_t symbols_due[$];
  int      failures = 0;
  bit      no_idle = 1'b0;

  barcode_check_digit_encoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_code_value(in_code_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pattern(out_pattern),
    .out_pattern_length(out_pattern_length),
    .out_check_digit(out_check_digit),
    .out_last(out_last)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic void push_symbol(logic [13:0] pattern, logic [3:0] length,
                                      logic [3:0] check, logic last);
    symbol_t s;
    s.pattern = pattern;
    s.length = length;
    s.check = check;
    s.last = last;
    symbols_due.push_back(s);
  endfunction

  function automatic void predict_symbols(logic [19:0] code);
    int value;
    int digits[6];
    int weighted;
    logic [3:0] check;
    value = (code > LARGEST_CODE) ? LARGEST_CODE : int'(code);
    for (int i = 0; i < 6; i++) begin
      digits[i] = value % 10;
      value = value / 10;
    end
    // Units, hundreds and ten-thousands carry weight three.
    weighted = 3 * (digits[0] + digits[2] + digits[4]) + digits[1] + digits[3] + digits[5];
    check = 4'((10 - weighted % 10) % 10);
    push_symbol(FRAME_START, EDGE_BITS, check, 1'b0);
    for (int i = 5; i >= 0; i--) begin
      push_symbol(BAR_TABLE[digits[i]], DIGIT_BITS, check, 1'b0);
    end
    push_symbol(BAR_TABLE[check], DIGIT_BITS, check, 1'b0);
    push_symbol(FRAME_STOP, EDGE_BITS, check, 1'b1);
  endfunction

  task automatic send_code(input logic [19:0] code);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_value <= code;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_symbols(code);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
  endtask

  task automatic reset_block();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_directed();
    for (int d = 0; d < 10; d++) send_code(20'(d));
    send_code(20'd999999);
    send_code(20'd1000000);
    send_code(20'hFFFFF);
    send_code(20'd123456);
    send_code(20'd987654);
    send_code(20'hAAAAA);
    send_code(20'h55555);
    send_code(20'd505050);
    send_code(20'd222222);
    send_code(20'd888888);
  endtask

  task automatic test_random_codes();
    for (int i = 0; i < 200; i++) begin
      no_idle = (i % 60) >= 48;
      send_code(20'($urandom_range(0, LARGEST_CODE)));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    wait_for_drain();
    send_code(20'($urandom_range(0, LARGEST_CODE)));
    send_code(20'($urandom_range(0, LARGEST_CODE)));
  endtask

  task automatic test_full_range();
    for (int i = 0; i < 100; i++) begin
      if (i % 10 == 0) begin
        send_code(20'($urandom_range(LARGEST_CODE - 20, LARGEST_CODE + 20)));
      end else begin
        send_code(20'($urandom));
      end
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 38; i++) send_code(20'($urandom_range(0, LARGEST_CODE)));
    no_idle = 1'b0;
  endtask

  initial begin
    int stall_cycles;
    symbol_t want;
    wait (rst_n === 1'b1);
    forever begin
      stall_cycles = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (symbols_due.size() == 0) begin
        $error("unexpected transfer: out_pattern %h", out_pattern);
        failures++;
      end else begin
        want = symbols_due.pop_front();
        if (out_pattern !== want.pattern) begin
          $error("out_pattern: expected %h, got %h", want.pattern, out_pattern);
          failures++;
        end
        if (out_pattern_length !== want.length) begin
          $error("out_pattern_length: expected %0d, got %0d", want.length, out_pattern_length);
          failures++;
        end
        if (out_check_digit !== want.check) begin
          $error("out_check_digit: expected %0d, got %0d", want.check, out_check_digit);
          failures++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_last);
          failures++;
        end
      end
    end
  end

  initial begin
    reset_block();
    test_directed();
    test_random_codes();
    test_drain_pause();
    test_full_range();
    test_back_to_back();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && symbols_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
    $display("testbench failed");
    $finish;
  end

endmodule
